### rtl/core/sexp_pkg.sv
// ---------------------------------------------------------------------------
// sexp_pkg: shared types and constants for the S-expression tokenizer
// Beat formats of both channels, token kind codes and character classes.
// ---------------------------------------------------------------------------
package sexp_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [62:0] number;
		logic        saturated;
		logic [7:0]  symbol_byte;
		logic        symbol_end;
		logic        run_last;
	} tok_item_t;

	localparam logic [2:0] KIND_NUMBER = 3'd0;
	localparam logic [2:0] KIND_OPEN   = 3'd1;
	localparam logic [2:0] KIND_CLOSE  = 3'd2;
	localparam logic [2:0] KIND_SYMBOL = 3'd3;
	localparam logic [2:0] KIND_END    = 3'd4;

	localparam logic [62:0] NUM_MAX = {63{1'b1}};

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_paren(input logic [7:0] c);
		return (c == CH_OPEN) || (c == CH_CLOSE);
	endfunction

	function automatic logic ends_symbol(input logic [7:0] c);
		return is_space(c) || (c == CH_SEMI) || is_paren(c);
	endfunction

endpackage

### rtl/core/sexp_lexer.sv
// ---------------------------------------------------------------------------
// sexp_lexer: lexer state and token decode
// Holds the lexer mode, the running number and the pending symbol byte, and
// turns one text beat into up to two token beats.
// ---------------------------------------------------------------------------
module sexp_lexer
	import sexp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  src_item_t item,
	output logic [1:0] res_cnt,
	output tok_item_t res0,
	output tok_item_t res1
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_NUMBER,
		MODE_SYMBOL
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [62:0] acc_q, acc_d;
	logic        sat_q, sat_d;
	logic [7:0]  held_q, held_d;

	logic [7:0]  c;
	logic [7:0]  c_off;
	logic [3:0]  d;
	logic [65:0] acc_x10;
	logic [66:0] acc_next;
	logic        ovf;
	logic        do_start;
	logic        have_a, have_b;
	tok_item_t   res_a, res_b;

	assign c        = item.text_byte;
	assign c_off    = c - CH_ZERO;
	assign d        = c_off[3:0];
	assign acc_x10  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};
	assign acc_next = {1'b0, acc_x10} + {63'd0, d};
	assign ovf      = |acc_next[66:63];

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		sat_d    = sat_q;
		held_d   = held_q;
		do_start = 1'b0;
		have_a   = 1'b0;
		have_b   = 1'b0;
		res_a    = '0;
		res_b    = '0;

		if (item.end_of_text) begin
			if (mode_q == MODE_NUMBER) begin
				have_a          = 1'b1;
				res_a.kind      = KIND_NUMBER;
				res_a.number    = acc_q;
				res_a.saturated = sat_q;
			end else if (mode_q == MODE_SYMBOL) begin
				have_a            = 1'b1;
				res_a.kind        = KIND_SYMBOL;
				res_a.symbol_byte = held_q;
				res_a.symbol_end  = 1'b1;
			end
			have_b     = 1'b1;
			res_b.kind = KIND_END;
			mode_d     = MODE_IDLE;
			acc_d      = '0;
			sat_d      = 1'b0;
			held_d     = '0;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_NEWLINE) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						if (sat_q || ovf) begin
							acc_d = NUM_MAX;
							sat_d = 1'b1;
						end else begin
							acc_d = acc_next[62:0];
						end
					end else begin
						have_a          = 1'b1;
						res_a.kind      = KIND_NUMBER;
						res_a.number    = acc_q;
						res_a.saturated = sat_q;
						acc_d           = '0;
						sat_d           = 1'b0;
						do_start        = 1'b1;
					end
				end
				MODE_SYMBOL: begin
					have_a            = 1'b1;
					res_a.kind        = KIND_SYMBOL;
					res_a.symbol_byte = held_q;
					if (ends_symbol(c)) begin
						res_a.symbol_end = 1'b1;
						held_d           = '0;
						do_start         = 1'b1;
					end else begin
						held_d = c;
					end
				end
				MODE_IDLE: begin
					do_start = 1'b1;
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			if (do_start) begin
				if (is_space(c)) begin
					mode_d = MODE_IDLE;
				end else if (c == CH_SEMI) begin
					mode_d = MODE_COMMENT;
				end else if (is_digit(c)) begin
					mode_d = MODE_NUMBER;
					acc_d  = {59'd0, d};
					sat_d  = 1'b0;
				end else if (is_paren(c)) begin
					mode_d     = MODE_IDLE;
					have_b     = 1'b1;
					res_b.kind = (c == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
				end else begin
					mode_d = MODE_SYMBOL;
					held_d = c;
				end
			end
		end

		res_cnt = {1'b0, have_a} + {1'b0, have_b};
		res0    = have_a ? res_a : res_b;
		res0.run_last = !(have_a && have_b);
		res1    = res_b;
		res1.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			sat_q  <= 1'b0;
			held_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			sat_q  <= sat_d;
			held_q <= held_d;
		end
	end

endmodule

### rtl/core/sexp_outq.sv
// ---------------------------------------------------------------------------
// sexp_outq: token output queue
// A four-entry shifting queue that takes up to two token beats per cycle and
// hands one beat per cycle to the output channel while that channel does not stall.
// ---------------------------------------------------------------------------
module sexp_outq
	import sexp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  tok_item_t  push0,
	input  tok_item_t  push1,
	input  logic       pop,
	output logic       valid,
	output tok_item_t  head,
	output logic       room
);

	localparam int DEPTH = 4;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_item_t        entry_q [DEPTH];
	tok_item_t        shifted [DEPTH];
	tok_item_t        entry_d [DEPTH];
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_ap;

	assign valid = (cnt_q != '0);
	assign head  = entry_q[0];
	assign room  = (cnt_q <= CNT_W'(DEPTH - 2));

	always_comb begin
		cnt_ap = cnt_q - {{(CNT_W-1){1'b0}}, pop};
		for (int i = 0; i < DEPTH - 1; i++) begin
			shifted[i] = pop ? entry_q[i+1] : entry_q[i];
		end
		shifted[DEPTH-1] = entry_q[DEPTH-1];
		for (int i = 0; i < DEPTH; i++) begin
			entry_d[i] = shifted[i];
			if ((push_cnt != 2'd0) && (cnt_ap == CNT_W'(i))) begin
				entry_d[i] = push0;
			end
			if ((push_cnt == 2'd2) && ((cnt_ap + CNT_W'(1)) == CNT_W'(i))) begin
				entry_d[i] = push1;
			end
		end
		cnt_d = cnt_ap + {{(CNT_W-2){1'b0}}, push_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### rtl/core/sexpr_tokenizer.sv
// ---------------------------------------------------------------------------
// sexpr_tokenizer: streaming S-expression tokenizer
// Splits a byte stream into number, parenthesis, symbol-byte and end tokens.
// ---------------------------------------------------------------------------
// The source channel (src_valid, src_stall, src_item) carries one text byte
// or an end-of-text mark per beat. The token channel (tok_valid, tok_stall,
// tok_item) carries one token per beat; run_last marks the final token that
// a source beat produced, and a source beat produces zero, one or two tokens.
// A source beat is registered on entry (item_s1) and decoded from that
// register, and its tokens are written into the output queue, whose head
// drives the token channel. One source beat is taken every cycle as long
// as beats produce at most one token each and tok_stall stays low; the
// token channel runs at one beat per cycle while tok_stall is low, so a
// beat that produces two tokens is absorbed by the four-entry output queue.
// Reset puts the lexer in its idle mode with no pending number or symbol
// and empties the queue. When the receiver stalls, the queue fills and
// src_stall rises once fewer than two entries are free; no token is dropped.
// ---------------------------------------------------------------------------
module sexpr_tokenizer
	import sexp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok_item
);

	logic       valid_s1;
	src_item_t  item_s1;
	logic       room;
	logic       fire;
	logic [1:0] res_cnt;
	tok_item_t  res0, res1;

	assign fire      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	sexp_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	sexp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (fire ? res_cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.pop      (tok_valid && !tok_stall),
		.valid    (tok_valid),
		.head     (tok_item),
		.room     (room)
	);

endmodule
